/* hdl/umd_pkg.sv */
// umd_pkg: shared field widths and stream bus widths for the unsigned magic divider.
// No dependencies; imported by the top level, its checker and the bench.
package umd_pkg;

    localparam int DATA_W    = 32;
    localparam int SHIFT_W   = 6;
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = 72;

endpackage

/* hdl/umd_serdiv.sv */
// umd_serdiv: restoring radix-2 divider, one quotient bit per cycle.
// Standalone; shared by the sequencer in unsigned_magic_divider.
module umd_serdiv #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_div, n_div;

    logic [WIDTH:0]   w_part;
    logic [WIDTH+1:0] w_diff;
    logic             w_ge;

    assign w_part = {r_rem, r_quo[WIDTH-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, r_div};
    assign w_ge   = ~w_diff[WIDTH+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[WIDTH-2:0], w_ge};
            n_rem = w_ge ? w_diff[WIDTH-1:0] : w_part[WIDTH-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* hdl/unsigned_magic_divider.sv */
// unsigned_magic_divider: finds magic multiplier, post shift and add flag for a divisor,
// then divides the dividend with them. Depends on umd_pkg and umd_serdiv.
//
// One request at a time: s_axis_tready is high only while idle. A zero divisor's result
// is valid in the cycle after the request. Otherwise the shared serial divider runs three
// divisions, the magic search runs up to WIDTH+1 steps through S_SRCH_A and S_SRCH_B,
// the high product comes from a shift-add multiplier, and S_FIN applies add and shift.
// Only the low WIDTH bits of divisor and dividend are used.
module unsigned_magic_divider #(
    parameter int WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] divisor, [63:32] dividend
    input  logic [umd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] magic, [37:32] post_shift, [38] add_needed, [70:39] quotient, [71] zero
    output logic [umd_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import umd_pkg::*;

    localparam int CNT_W  = $clog2(WIDTH);
    localparam int EXPO_W = $clog2(2 * WIDTH + 1);
    localparam int SH_W   = $clog2(WIDTH + 1);
    localparam logic [WIDTH-1:0] TOPBIT = {1'b1, {(WIDTH-1){1'b0}}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV_T  = 4'd1;
    localparam logic [3:0] S_DIV_A  = 4'd2;
    localparam logic [3:0] S_DIV_B  = 4'd3;
    localparam logic [3:0] S_SRCH_A = 4'd4;
    localparam logic [3:0] S_SRCH_B = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [EXPO_W-1:0]  r_expo, n_expo;
    logic [SH_W-1:0]    r_sh, n_sh;
    logic               r_addf, n_addf;
    logic [WIDTH-1:0]   r_d, n_d;
    logic [WIDTH-1:0]   r_n, n_n;
    logic [WIDTH-1:0]   r_nlim, n_nlim;
    logic [WIDTH-1:0]   r_qa, n_qa;
    logic [WIDTH-1:0]   r_ra, n_ra;
    logic [WIDTH-1:0]   r_qb, n_qb;
    logic [WIDTH-1:0]   r_rb, n_rb;
    logic [WIDTH-1:0]   r_mult, n_mult;
    logic [2*WIDTH-1:0] r_prod, n_prod;
    logic [DATA_W-1:0]  r_magic, n_magic;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic               r_add, n_add;
    logic [DATA_W-1:0]  r_quot, n_quot;

    logic               div_start;
    logic [WIDTH-1:0]   div_dividend;
    logic [WIDTH-1:0]   div_divisor;
    logic               div_done;
    logic [WIDTH-1:0]   div_quot;
    logic [WIDTH-1:0]   div_rem;

    logic [WIDTH-1:0]   w_in_d;
    logic [WIDTH-1:0]   w_in_n;
    logic [WIDTH:0]     w_two_ra;
    logic [WIDTH+1:0]   w_diff_a;
    logic               w_cond_a;
    logic [WIDTH:0]     w_two_rb;
    logic [WIDTH+1:0]   w_diff_b;
    logic               w_cond_b;
    logic [WIDTH-1:0]   w_bound;
    logic               w_more;
    logic [WIDTH-1:0]   w_addend;
    logic [WIDTH:0]     w_psum;
    logic [WIDTH:0]     w_fsum;
    logic [WIDTH:0]     w_fshift;

    umd_serdiv #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign w_in_d = WIDTH'(s_axis_tdata[DATA_W-1:0]);
    assign w_in_n = WIDTH'(s_axis_tdata[S_TDATA_W-1:DATA_W]);

    assign w_two_ra = {r_ra, 1'b0};
    assign w_diff_a = {1'b0, w_two_ra} - {2'b00, r_nlim};
    assign w_cond_a = ~w_diff_a[WIDTH+1];
    assign w_two_rb = {r_rb, 1'b1};
    assign w_diff_b = {1'b0, w_two_rb} - {2'b00, r_d};
    assign w_cond_b = ~w_diff_b[WIDTH+1];

    assign w_bound = r_d - WIDTH'(1) - r_rb;
    assign w_more  = (r_expo < EXPO_W'(2 * WIDTH)) &&
                     ((r_qa < w_bound) || ((r_qa == w_bound) && (r_ra == '0)));

    assign w_addend = r_prod[0] ? r_mult : '0;
    assign w_psum   = {1'b0, r_prod[2*WIDTH-1:WIDTH]} + {1'b0, w_addend};
    assign w_fsum   = {1'b0, r_prod[2*WIDTH-1:WIDTH]} + {1'b0, (r_addf ? r_n : '0)};
    assign w_fshift = w_fsum >> r_sh;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_expo       = r_expo;
        n_sh         = r_sh;
        n_addf       = r_addf;
        n_d          = r_d;
        n_n          = r_n;
        n_nlim       = r_nlim;
        n_qa         = r_qa;
        n_ra         = r_ra;
        n_qb         = r_qb;
        n_rb         = r_rb;
        n_mult       = r_mult;
        n_prod       = r_prod;
        n_magic      = r_magic;
        n_shift      = r_shift;
        n_add        = r_add;
        n_quot       = r_quot;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_d;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_d  = w_in_d;
                    n_n  = w_in_n;
                    if (w_in_d == '0) begin
                        n_magic = '0;
                        n_shift = '0;
                        n_add   = 1'b0;
                        n_quot  = DATA_W'({WIDTH{1'b1}});
                        n_state = S_OUT;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = '0 - w_in_d;
                        div_divisor  = w_in_d;
                        n_state      = S_DIV_T;
                    end
                end
            end
            S_DIV_T: begin
                if (div_done) begin
                    n_nlim       = ~div_rem;
                    div_start    = 1'b1;
                    div_dividend = TOPBIT;
                    div_divisor  = ~div_rem;
                    n_state      = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (div_done) begin
                    n_qa         = div_quot;
                    n_ra         = div_rem;
                    div_start    = 1'b1;
                    div_dividend = TOPBIT - WIDTH'(1);
                    div_divisor  = r_d;
                    n_state      = S_DIV_B;
                end
            end
            S_DIV_B: begin
                if (div_done) begin
                    n_qb    = div_quot;
                    n_rb    = div_rem;
                    n_expo  = EXPO_W'(WIDTH - 1);
                    n_addf  = 1'b0;
                    n_state = S_SRCH_A;
                end
            end
            S_SRCH_A: begin
                n_expo = r_expo + EXPO_W'(1);
                n_qa   = {r_qa[WIDTH-2:0], w_cond_a};
                n_ra   = w_cond_a ? w_diff_a[WIDTH-1:0] : w_two_ra[WIDTH-1:0];
                if (w_cond_b) begin
                    if (r_qb[WIDTH-1] || (r_qb[WIDTH-2:0] == '1)) begin
                        n_addf = 1'b1;
                    end
                end else if (r_qb[WIDTH-1]) begin
                    n_addf = 1'b1;
                end
                n_qb    = {r_qb[WIDTH-2:0], w_cond_b};
                n_rb    = w_cond_b ? w_diff_b[WIDTH-1:0] : w_two_rb[WIDTH-1:0];
                n_state = S_SRCH_B;
            end
            S_SRCH_B: begin
                if (w_more) begin
                    n_state = S_SRCH_A;
                end else begin
                    n_mult  = r_qb + WIDTH'(1);
                    n_sh    = SH_W'(r_expo - EXPO_W'(WIDTH));
                    n_prod  = {{WIDTH{1'b0}}, r_n};
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = {w_psum, r_prod[WIDTH-1:1]};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_magic = DATA_W'(r_mult);
                n_shift = SHIFT_W'(r_sh);
                n_add   = r_addf;
                n_quot  = DATA_W'(w_fshift[WIDTH-1:0]);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_expo  <= n_expo;
        r_sh    <= n_sh;
        r_addf  <= n_addf;
        r_d     <= n_d;
        r_n     <= n_n;
        r_nlim  <= n_nlim;
        r_qa    <= n_qa;
        r_ra    <= n_ra;
        r_qb    <= n_qb;
        r_rb    <= n_rb;
        r_mult  <= n_mult;
        r_prod  <= n_prod;
        r_magic <= n_magic;
        r_shift <= n_shift;
        r_add   <= n_add;
        r_quot  <= n_quot;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_quot, r_add, r_shift, r_magic};

endmodule

/* hdl/umd_check.sv */
// umd_check: port-level assertions for unsigned_magic_divider, bound to the top level.
// Depends on umd_pkg.
module umd_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [umd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import umd_pkg::*;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready did not drop after a request");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("block not idle after result was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind unsigned_magic_divider umd_check u_umd_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/unsigned_magic_divider_tb.sv */
// unsigned_magic_divider_tb: self-checking bench for the magic-number unsigned divider.
// Scoreboard class predicts magic, shift, add flag and quotient per request.
// Depends on umd_pkg and unsigned_magic_divider.
module unsigned_magic_divider_tb;
    import umd_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  magic;
        logic [SHIFT_W-1:0] post_shift;
        logic               add_needed;
        logic [DATA_W-1:0]  quotient;
    } t_magic_result;

    class t_magic_div_scoreboard;
        localparam bit [31:0] TOP_BIT = 32'h8000_0000;
        t_magic_result expected_q[$];
        int            errors = 0;

        function t_magic_result divide_by_magic(bit [31:0] d, bit [31:0] n);
            bit [31:0]   nlim, qa, ra, qb, rb, bound, mult, high, sum, quo;
            bit [63:0]   prod;
            int unsigned expo, sh;
            bit          addf, carry;
            t_magic_result r;
            addf  = 1'b0;
            carry = 1'b0;
            if (d == 32'd0) begin
                r.magic      = '0;
                r.post_shift = '0;
                r.add_needed = 1'b0;
                r.quotient   = '1;
                return r;
            end
            nlim = 32'hFFFF_FFFF - ((32'd0 - d) % d);
            expo = 31;
            qa   = TOP_BIT / nlim;
            ra   = TOP_BIT - qa * nlim;
            qb   = (TOP_BIT - 32'd1) / d;
            rb   = TOP_BIT - 32'd1 - qb * d;
            do begin
                expo++;
                if (ra >= nlim - ra) begin
                    qa = (qa << 1) + 32'd1;
                    ra = (ra << 1) - nlim;
                end else begin
                    qa = qa << 1;
                    ra = ra << 1;
                end
                if (rb + 32'd1 >= d - rb) begin
                    if (qb >= TOP_BIT - 32'd1)
                        addf = 1'b1;
                    qb = (qb << 1) + 32'd1;
                    rb = (rb << 1) + 32'd1 - d;
                end else begin
                    if (qb >= TOP_BIT)
                        addf = 1'b1;
                    qb = qb << 1;
                    rb = (rb << 1) + 32'd1;
                end
                bound = d - 32'd1 - rb;
            end while (expo < 64 && (qa < bound || (qa == bound && ra == 32'd0)));
            mult = qb + 32'd1;
            sh   = expo - 32;
            prod = {32'd0, mult} * {32'd0, n};
            high = prod[63:32];
            sum  = high;
            if (addf) begin
                sum   = high + n;
                carry = sum < high;
            end
            if (sh == 0)
                quo = sum;
            else if (sh >= 32)
                quo = (sh == 32 && carry) ? 32'd1 : 32'd0;
            else begin
                quo = sum >> sh;
                if (carry)
                    quo |= 32'd1 << (32 - sh);
            end
            r.magic      = mult;
            r.post_shift = 6'(sh);
            r.add_needed = addf;
            r.quotient   = quo;
            return r;
        endfunction

        function void note_request(bit [31:0] d, bit [31:0] n);
            expected_q.push_back(divide_by_magic(d, n));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_magic_result exp_r, got;
            got.magic      = tdata[31:0];
            got.post_shift = tdata[37:32];
            got.add_needed = tdata[38];
            got.quotient   = tdata[70:39];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, tdata);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.magic !== exp_r.magic) begin
                $display("%0t: magic exp %h got %h", $time, exp_r.magic, got.magic);
                errors++;
            end
            if (got.post_shift !== exp_r.post_shift) begin
                $display("%0t: post_shift exp %0d got %0d", $time, exp_r.post_shift,
                         got.post_shift);
                errors++;
            end
            if (got.add_needed !== exp_r.add_needed) begin
                $display("%0t: add_needed exp %b got %b", $time, exp_r.add_needed,
                         got.add_needed);
                errors++;
            end
            if (got.quotient !== exp_r.quotient) begin
                $display("%0t: quotient exp %h got %h", $time, exp_r.quotient, got.quotient);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [31:0] divisor, [63:32] dividend
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [31:0] magic, [37:32] post_shift, [38] add_needed, [70:39] quotient, [71] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_magic_div_scoreboard sb = new();
    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned recv_hold = 0;
    bit          hold_go = 1'b0;
    bit          hold_taken = 1'b0;

    unsigned_magic_divider #(.WIDTH(DATA_W)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side: check, then pick next tready (long hold-off has priority)
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (hold_go && !hold_taken) begin
            hold_taken    <= 1'b1;
            m_axis_tready <= 1'b0;
            recv_hold     <= 600;
        end else if (recv_hold != 0) begin
            m_axis_tready <= 1'b0;
            recv_hold     <= recv_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(input bit [31:0] d, input bit [31:0] n);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {n, d};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(d, n);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        bit [31:0] d, n;
        int        k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner divisors: zero, one, small values, powers of two, near-top values
        send_request(32'd0, 32'd12345);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd1, 32'd0);
        send_request(32'd1, 32'hFFFF_FFFF);
        send_request(32'd2, 32'hFFFF_FFFF);
        send_request(32'd3, 32'hFFFF_FFFF);
        send_request(32'd3, 32'd0);
        send_request(32'd5, 32'd1234567);
        send_request(32'd6, 32'd100);
        send_request(32'd7, 32'hFFFF_FFFF);
        send_request(32'd7, 32'd7);
        send_request(32'd10, 32'd99);
        send_request(32'd641, 32'hFFFF_FFFF);
        send_request(32'd16, 32'hDEAD_BEEF);
        send_request(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h8000_0001, 32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'd25, 32'd0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 57; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 57; end
                default: begin idle_pct = 38; stall_pct <= 38; end
            endcase
            for (int i = 0; i < 275; i++) begin
                if (phase == 2 && i == 5)
                    hold_go <= 1'b1;
                if (i == 137)
                    drain();
                k = $urandom_range(31);
                case ($urandom_range(5))
                    0: d = $urandom_range(16, 1);
                    1: d = $urandom_range(65535, 1);
                    2: d = $urandom;
                    3: d = 32'd1 << k;
                    4: d = (32'd1 << k) + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
                    default: d = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
                endcase
                case ($urandom_range(3))
                    0: n = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom_range(3);
                    1: n = d * $urandom + $urandom_range(2) - 32'd1;
                    default: n = $urandom;
                endcase
                send_request(d, n);
            end
            drain();
        end

        repeat (250) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
